// ===== sv/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg
// Shared codes for the double-ended queue: request actions and result status.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int unsigned ActionW = 3;
  localparam int unsigned StatusW = 2;
  localparam int unsigned DataW   = 32;
  localparam int unsigned CountW  = 5;

  typedef enum logic [ActionW-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_PEEK_FRONT = 3'd4,
    ACT_PEEK_BACK  = 3'd5
  } action_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Data returned by a pop or peek of an empty queue.
  localparam logic [DataW-1:0] EmptyData = '1;

endpackage

// ===== sv/deq_ram.sv =====
// ----------------------------------------------------------------------------
// deq_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module deq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/double_ended_queue.sv =====
// A push or a request on an empty queue shows its result in the cycle after
// the transfer; a pop or peek of a stored entry passes through the RAM read
// register and then the output register. Pushes go at one per cycle while the
// output is not stalled; no new request is taken while a RAM read is in flight.
// Reset clears the head, the count, the read-busy flag and the output valid;
// RAM contents are left as they are and are never read before a push writes them.
// ----------------------------------------------------------------------------
// double_ended_queue
// Ring-buffer deque of signed 32-bit values with push, pop and peek at both
// ends. Entries live in a synchronous RAM; head and count are registers.
// ----------------------------------------------------------------------------
module double_ended_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [deq_pkg::ActionW-1:0]      action_i,
  input  logic signed [deq_pkg::DataW-1:0] value_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [deq_pkg::DataW-1:0] data_o,
  output logic [deq_pkg::StatusW-1:0]      status_o,
  output logic [deq_pkg::CountW-1:0]       count_o
);

  import deq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = CW + 1;
  localparam logic [AW-1:0] LastPos  = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FullCnt  = CW'(DEPTH);
  localparam logic [SW-1:0] DepthSum = SW'(DEPTH);

  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          out_valid_q, out_valid_d;
  logic [DataW-1:0]   out_data_q;
  logic [StatusW-1:0] out_status_q;
  logic [CW-1:0]      out_cnt_q;

  logic             accept, out_free;
  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [DataW-1:0] ram_rdata;
  logic [DataW-1:0] res_data;
  logic [StatusW-1:0] res_status;
  logic             needs_read;

  logic [AW-1:0] head_dec, head_inc, back_pos, tail_pos;
  logic [SW-1:0] back_sum, tail_sum;
  logic          is_empty, is_full;

  assign out_free   = ~out_valid_q | ~out_stall_i;
  assign in_stall_o = busy_q | ~out_free;
  assign accept     = in_valid_i & ~in_stall_o;

  assign is_empty = (cnt_q == '0);
  assign is_full  = (cnt_q == FullCnt);

  // Ring arithmetic; sums stay below twice the depth, so one subtract wraps.
  assign head_dec = (head_q == '0) ? LastPos : head_q - AW'(1);
  assign head_inc = (head_q == LastPos) ? '0 : head_q + AW'(1);
  assign back_sum = SW'(head_q) + SW'(cnt_q) - SW'(1);
  assign tail_sum = SW'(head_q) + SW'(cnt_q);
  always_comb begin
    logic [SW-1:0] b, t;
    b = (back_sum >= DepthSum) ? back_sum - DepthSum : back_sum;
    t = (tail_sum >= DepthSum) ? tail_sum - DepthSum : tail_sum;
    back_pos = b[AW-1:0];
    tail_pos = t[AW-1:0];
  end

  always_comb begin
    head_d     = head_q;
    cnt_d      = cnt_q;
    ram_we     = 1'b0;
    ram_waddr  = head_dec;
    ram_re     = 1'b0;
    ram_raddr  = head_q;
    res_data   = '0;
    res_status = ST_OK;
    needs_read = 1'b0;
    if (accept) begin
      unique case (action_i)
        ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
          if (is_full) begin
            res_status = ST_FULL;
          end else begin
            ram_we = 1'b1;
            cnt_d  = cnt_q + CW'(1);
            if (action_i == ACT_PUSH_FRONT) begin
              head_d    = head_dec;
              ram_waddr = head_dec;
            end else begin
              ram_waddr = tail_pos;
            end
          end
        end
        ACT_POP_FRONT, ACT_POP_BACK, ACT_PEEK_FRONT, ACT_PEEK_BACK: begin
          if (is_empty) begin
            res_data   = EmptyData;
            res_status = ST_EMPTY;
          end else begin
            ram_re     = 1'b1;
            needs_read = 1'b1;
            if (action_i == ACT_POP_FRONT || action_i == ACT_PEEK_FRONT) begin
              ram_raddr = head_q;
            end else begin
              ram_raddr = back_pos;
            end
            if (action_i == ACT_POP_FRONT) begin
              head_d = head_inc;
            end
            if (action_i == ACT_POP_FRONT || action_i == ACT_POP_BACK) begin
              cnt_d = cnt_q - CW'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  deq_ram #(
    .Width (DataW),
    .Depth (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (value_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // A read in flight lands in the output register the cycle after; the
  // output register is known to be empty then, since the transfer required it.
  always_comb begin
    busy_d      = accept & needs_read;
    out_valid_d = out_valid_q;
    if (accept && !needs_read) begin
      out_valid_d = 1'b1;
    end else if (busy_q) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      cnt_q       <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      cnt_q       <= cnt_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_status_q <= res_status;
      out_cnt_q    <= cnt_d;
      if (!needs_read) begin
        out_data_q <= res_data;
      end
    end else if (busy_q) begin
      out_data_q <= ram_rdata;
    end
  end

  logic [CW+CountW-1:0] cnt_ext;
  assign cnt_ext = {{CountW{1'b0}}, out_cnt_q};

  assign out_valid_o = out_valid_q;
  assign data_o      = out_data_q;
  assign status_o    = out_status_q;
  assign count_o     = cnt_ext[CountW-1:0];

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCnt)
    else $error("entry count above depth");

  a_head_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= LastPos)
    else $error("head index out of range");

  a_read_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (!out_valid_q && in_stall_o))
    else $error("read return collides with a pending result");

  a_read_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |=> out_valid_q)
    else $error("read data not presented after read");

  a_push_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && ram_we) |=> (cnt_q == $past(cnt_q) + CW'(1)))
    else $error("push did not grow the count");

endmodule
